// ===== hdl/assert_macros.svh =====
// Assertion helpers; clk and rst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked out of reset only.
`define BVM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset only.
`define BVM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define BVM_ASSERT_NXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/bvm_pkg.sv =====
package bvm_pkg;

  localparam int CW = 32;          // coordinate width
  localparam int RW = CW - 1;      // radius width
  localparam int SQW = 2 * CW + 2; // sum of three squares
  localparam int DW = CW + 1;      // distance (square root) width
  localparam int REMW = DW + 3;    // square-root remainder width
  localparam int CNTW = 6;         // holds up to DW iterations

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SQ   = 8'b0000_0010,
    ST_ROOT = 8'b0000_0100,
    ST_TEST = 8'b0000_1000,
    ST_MUL  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_CUP  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

endpackage

// ===== hdl/bounding_volume_merge_core.sv =====
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     start flag, box corners, centre, radius
// out_      output     out_valid / out_ready   merged box, centre, radius
//
// A start request passes through the ST_FIN state to the result register; a merge is paced
// by the bit-serial unit (no divides when one sphere already holds the other): 33 square-root
// steps, then one 32-step divide per axis, each after a single pass through the shared
// multiplier. in_ready is high only while the sequencer is idle; a result left waiting on
// out_ready holds the sequencer at its last step. Reset (rst_n low, synchronous) clears the
// accumulator to a zero box and a zero-radius sphere at the origin.
module bounding_volume_merge_core
  import bvm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_start_req,
  input  logic signed [CW-1:0] in_low_x,
  input  logic signed [CW-1:0] in_low_y,
  input  logic signed [CW-1:0] in_low_z,
  input  logic signed [CW-1:0] in_high_x,
  input  logic signed [CW-1:0] in_high_y,
  input  logic signed [CW-1:0] in_high_z,
  input  logic signed [CW-1:0] in_ctr_x,
  input  logic signed [CW-1:0] in_ctr_y,
  input  logic signed [CW-1:0] in_ctr_z,
  input  logic        [RW-1:0] in_rad,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CW-1:0] out_low_x,
  output logic signed [CW-1:0] out_low_y,
  output logic signed [CW-1:0] out_low_z,
  output logic signed [CW-1:0] out_high_x,
  output logic signed [CW-1:0] out_high_y,
  output logic signed [CW-1:0] out_high_z,
  output logic signed [CW-1:0] out_ctr_x,
  output logic signed [CW-1:0] out_ctr_y,
  output logic signed [CW-1:0] out_ctr_z,
  output logic        [RW-1:0] out_rad
);

  state_t state_r;

  logic signed [CW-1:0] acc_lo_r [3];
  logic signed [CW-1:0] acc_hi_r [3];
  logic signed [CW-1:0] acc_c_r  [3];
  logic        [RW-1:0] acc_rad_r;

  logic signed [CW-1:0] cin_r [3];
  logic        [RW-1:0] rin_r;
  logic        [CW-1:0] mag_r [3];
  logic                 neg_r [3];
  logic [1:0]           ax_r;
  logic                 ph_r;
  logic [CNTW-1:0]      cnt_r;
  logic [2*CW-1:0]      prod_r;
  logic [SQW-1:0]       sq_r;
  logic [REMW-1:0]      rem_r;
  logic [DW-1:0]        root_r;
  logic [DW-1:0]        k_r;
  logic [CW-1:0]        quo_r;
  logic                 out_valid_r;

  logic signed [CW-1:0] lo_in [3];
  logic signed [CW-1:0] hi_in [3];
  logic signed [CW-1:0] c_in  [3];

  assign lo_in = '{in_low_x, in_low_y, in_low_z};
  assign hi_in = '{in_high_x, in_high_y, in_high_z};
  assign c_in  = '{in_ctr_x, in_ctr_y, in_ctr_z};

  logic accept;
  logic out_free;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Shared multiplier: squares first, then magnitude times the centre shift.
  logic [CW-1:0]   mul_a;
  logic [DW-1:0]   mul_b;
  logic [CW+DW-1:0] mul_p;
  assign mul_a = mag_r[ax_r];
  assign mul_b = (state_r == ST_MUL) ? k_r : {1'b0, mag_r[ax_r]};
  assign mul_p = mul_a * mul_b;

  // Square-root step.
  logic [REMW-1:0] sr_t;
  logic [REMW-1:0] sr_trial;
  logic            sr_ge;
  assign sr_t     = {rem_r[REMW-3:0], sq_r[SQW-1 -: 2]};
  assign sr_trial = {1'b0, root_r, 2'b01};
  assign sr_ge    = (sr_t >= sr_trial);

  // Divide step.
  logic [DW:0] dv_t;
  logic        dv_ge;
  assign dv_t  = {rem_r[DW-1:0], quo_r[CW-1]};
  assign dv_ge = (dv_t >= {1'b0, root_r});

  // Containment tests and merged radius.
  logic          in_big, acc_big, in_holds, acc_holds;
  logic [DW:0]   rsum;
  logic [DW-1:0] r_full;
  assign in_big    = (rin_r >= acc_rad_r);
  assign acc_big   = (acc_rad_r >= rin_r);
  assign in_holds  = in_big  && ({2'b0, rin_r - acc_rad_r} >= root_r);
  assign acc_holds = acc_big && ({2'b0, acc_rad_r - rin_r} >= root_r);
  assign rsum      = {3'b0, acc_rad_r} + {3'b0, rin_r} + {1'b0, root_r};
  assign r_full    = rsum[DW:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_rad_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        acc_lo_r[i] <= '0;
        acc_hi_r[i] <= '0;
        acc_c_r[i]  <= '0;
      end
    end else begin
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            rin_r <= in_rad;
            ax_r  <= 2'd0;
            ph_r  <= 1'b0;
            sq_r  <= '0;
            for (int i = 0; i < 3; i++) begin
              cin_r[i] <= c_in[i];
              if (in_start_req) begin
                acc_lo_r[i] <= lo_in[i];
                acc_hi_r[i] <= hi_in[i];
                acc_c_r[i]  <= c_in[i];
              end else begin
                if (lo_in[i] < acc_lo_r[i]) acc_lo_r[i] <= lo_in[i];
                if (acc_hi_r[i] < hi_in[i]) acc_hi_r[i] <= hi_in[i];
                neg_r[i] <= (acc_c_r[i] < c_in[i]);
                mag_r[i] <= (acc_c_r[i] < c_in[i]) ? CW'(c_in[i] - acc_c_r[i])
                                                    : CW'(acc_c_r[i] - c_in[i]);
              end
            end
            if (in_start_req) begin
              acc_rad_r <= in_rad;
              state_r   <= ST_FIN;
            end else begin
              state_r <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          ph_r <= !ph_r;
          if (!ph_r) begin
            prod_r <= mul_p[2*CW-1:0];
          end else begin
            sq_r <= sq_r + {2'b0, prod_r};
            if (ax_r == 2'd2) begin
              rem_r   <= '0;
              root_r  <= '0;
              cnt_r   <= '0;
              state_r <= ST_ROOT;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        ST_ROOT: begin
          sq_r  <= {sq_r[SQW-3:0], 2'b00};
          rem_r <= sr_ge ? sr_t - sr_trial : sr_t;
          root_r <= {root_r[DW-2:0], sr_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(DW - 1)) state_r <= ST_TEST;
        end
        ST_TEST: begin
          if (in_holds) begin
            for (int i = 0; i < 3; i++) acc_c_r[i] <= cin_r[i];
            acc_rad_r <= rin_r;
            state_r   <= ST_FIN;
          end else if (acc_holds) begin
            state_r <= ST_FIN;
          end else begin
            // merged radius saturates; the unsaturated value drives the centre
            acc_rad_r <= (r_full[DW-1:RW] != '0) ? {RW{1'b1}} : r_full[RW-1:0];
            k_r       <= r_full - {2'b0, rin_r};
            ax_r      <= 2'd0;
            state_r   <= ST_MUL;
          end
        end
        ST_MUL: begin
          rem_r   <= {{(REMW-DW){1'b0}}, mul_p[CW+DW-1:CW]};
          quo_r   <= mul_p[CW-1:0];
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= {{(REMW-DW){1'b0}}, dv_ge ? DW'(dv_t - {1'b0, root_r}) : dv_t[DW-1:0]};
          quo_r <= {quo_r[CW-2:0], dv_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(CW - 1)) state_r <= ST_CUP;
        end
        ST_CUP: begin
          // step from the incoming centre towards the accumulated one
          acc_c_r[ax_r] <= neg_r[ax_r] ? cin_r[ax_r] - $signed(quo_r)
                                       : cin_r[ax_r] + $signed(quo_r);
          if (ax_r == 2'd2) begin
            state_r <= ST_FIN;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result register; hold until taken.
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_low_x  <= acc_lo_r[0];
      out_low_y  <= acc_lo_r[1];
      out_low_z  <= acc_lo_r[2];
      out_high_x <= acc_hi_r[0];
      out_high_y <= acc_hi_r[1];
      out_high_z <= acc_hi_r[2];
      out_ctr_x  <= acc_c_r[0];
      out_ctr_y  <= acc_c_r[1];
      out_ctr_z  <= acc_c_r[2];
      out_rad    <= acc_rad_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/bvm_checker.sv =====
`include "assert_macros.svh"

module bvm_checker
  import bvm_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          in_start_req,
  input logic [RW-1:0] in_rad,
  input logic          out_valid,
  input logic          out_ready,
  input logic [RW-1:0] out_rad
);

  `BVM_ASSERT_NXT_ALWAYS(a_reset_idle, !rst_n, in_ready && !out_valid)
  `BVM_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `BVM_ASSERT_IMP(a_start_loads, in_valid && in_ready && in_start_req && !out_valid,
    ##2 (out_valid && out_rad == $past(in_rad, 2)))
  `BVM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rad))

endmodule

bind bounding_volume_merge_core bvm_checker u_bvm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_start_req (in_start_req),
  .in_rad       (in_rad),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_rad      (out_rad)
);
